FILE: rtl/core/rpfl_pkg.sv
// Shared widths, codes and control structs for the page frame allocator.
package rpfl_pkg;

  localparam int ADDR_W   = 28;  // physical byte address
  localparam int HIGH_W   = 29;  // exclusive upper bound register
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 3;
  localparam int REFOUT_W = 8;   // reference count as reported
  localparam int FREE_W   = 17;  // free-frame counter
  localparam int CFG_W    = 29;  // widest configuration register
  localparam int CFG_IDX_W = 1;

  localparam logic [FREE_W-1:0] FREE_MAX   = '1;
  localparam logic [HIGH_W-1:0] HIGH_RESET = 29'h0E00_0000;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC      = 3'd0,
    MODE_FREE       = 3'd1,
    MODE_FREE_UNCHK = 3'd2,
    MODE_REF_INC    = 3'd3,
    MODE_REF_DEC    = 3'd4,
    MODE_REF_READ   = 3'd5,
    MODE_COUNT_FREE = 3'd6,
    MODE_NOP        = 3'd7
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_BADADDR = 3'd2,
    ST_SHARED  = 3'd3,
    ST_COUNT   = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT  = 1'd0,
    CFG_HIGH_LIMIT = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;  // write one zero entry of the count store
    logic load;   // accept a word, start memory reads
    logic exec;   // apply the operation, load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // final entry of the clearing pass
    logic out_free;    // output register free, or emptied this cycle
  } stat_t;

endpackage

FILE: rtl/core/rpfl_chan_if.sv
// Request and response channel interfaces of the page frame allocator.
interface rpfl_req_if import rpfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] phys_addr;

  modport source (output valid, mode, phys_addr, input ready);
  modport sink   (input valid, mode, phys_addr, output ready);
endinterface

interface rpfl_rsp_if import rpfl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   page_addr;
  logic [REFOUT_W-1:0] ref_count;
  logic [FREE_W-1:0]   free_frames;

  modport source (output valid, status, page_addr, ref_count, free_frames, input ready);
  modport sink   (input valid, status, page_addr, ref_count, free_frames, output ready);
endinterface

FILE: rtl/core/rpfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/rpfl_ctrl.sv
// Sequencer: clearing pass after reset, then accept / execute per word.
module rpfl_ctrl import rpfl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait here while the previous result is still unclaimed
        if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: rtl/core/rpfl_dpath.sv
// Datapath: limits, list head, free counter, link and count stores, output register.
module rpfl_dpath import rpfl_pkg::*; #(
  parameter int NUM_FRAMES = 65536,
  parameter int PAGE_SHIFT = 12,
  parameter int REF_BITS   = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // request payload
  input  logic [MODE_W-1:0]    mode,
  input  logic [ADDR_W-1:0]    phys_addr,
  // response
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic [ADDR_W-1:0]    page_addr,
  output logic [REFOUT_W-1:0]  ref_count,
  output logic [FREE_W-1:0]    free_frames,
  // control
  input  cmd_t                 cmd,
  output stat_t                stat
);

  localparam int IDX_W = $clog2(NUM_FRAMES);
  localparam int LINK_W = IDX_W + 1;
  localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((1 << PAGE_SHIFT) - 1);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);

  // configuration registers
  logic [ADDR_W-1:0] low_limit;
  logic [HIGH_W-1:0] high_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= '0;
      high_limit <= HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_LOW_LIMIT:  low_limit  <= cfg_data[ADDR_W-1:0];
        CFG_HIGH_LIMIT: high_limit <= cfg_data[HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  // address checks on the incoming word
  logic [ADDR_W-1:0] frame_no;
  logic              in_addr_ok;
  logic [IDX_W-1:0]  in_idx;

  always_comb begin
    frame_no   = phys_addr >> PAGE_SHIFT;
    in_idx     = frame_no[IDX_W-1:0];
    in_addr_ok = ((phys_addr & OFF_MASK) == '0)
               && (phys_addr >= low_limit)
               && ({1'b0, phys_addr} < high_limit)
               && (32'(frame_no) < 32'(NUM_FRAMES));
  end

  // latched operation
  mode_e            op_mode;
  logic             op_ok;
  logic [IDX_W-1:0] op_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode <= mode_e'(mode);
      op_ok   <= in_addr_ok;
      op_idx  <= in_idx;
    end
  end

  // clearing pass over the count store
  logic [IDX_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign stat.clear_last = (clr_cnt == LAST_IDX);
  assign stat.out_free   = !out_valid || out_ready;

  // list head and free counter
  logic [IDX_W-1:0]  head_index, head_index_next;
  logic              head_valid, head_valid_next;
  logic [FREE_W-1:0] free_total, free_total_next;

  // memories
  logic              link_we;
  logic [LINK_W-1:0] link_rd;
  logic              ref_we;
  logic [IDX_W-1:0]  ref_waddr;
  logic [REF_BITS-1:0] ref_wdata, ref_rd;

  // link store: {valid, next index}
  rpfl_ram #(.WIDTH(LINK_W), .DEPTH(NUM_FRAMES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (op_idx),
    .wdata ({head_valid, head_index}),
    .re    (cmd.load),
    .raddr (head_index),
    .rdata (link_rd)
  );

  rpfl_ram #(.WIDTH(REF_BITS), .DEPTH(NUM_FRAMES)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .re    (cmd.load),
    .raddr (in_idx),
    .rdata (ref_rd)
  );

  // operation decode and update
  status_e             res_status;
  logic [ADDR_W-1:0]   res_page;
  logic [REF_BITS-1:0] res_refs;
  logic                do_push;
  logic [63:0]         page_wide;
  logic [15:0]         refs_wide;

  always_comb begin
    res_status      = ST_OK;
    res_page        = '0;
    res_refs        = '0;
    do_push         = 1'b0;
    link_we         = 1'b0;
    ref_we          = 1'b0;
    ref_waddr       = op_idx;
    ref_wdata       = '0;
    head_index_next = head_index;
    head_valid_next = head_valid;
    free_total_next = free_total;
    page_wide       = 64'(head_index) << PAGE_SHIFT;

    unique case (op_mode)
      MODE_ALLOC: begin
        if (head_valid) begin
          head_index_next = link_rd[IDX_W-1:0];
          head_valid_next = link_rd[IDX_W];
          ref_we          = cmd.exec;
          ref_waddr       = head_index;
          ref_wdata       = REF_BITS'(1);
          if (free_total != '0) begin
            free_total_next = free_total - 1'b1;
          end
          res_page = page_wide[ADDR_W-1:0];
          res_refs = REF_BITS'(1);
        end else begin
          res_status = ST_EMPTY;
        end
      end
      MODE_FREE, MODE_FREE_UNCHK, MODE_REF_INC, MODE_REF_DEC, MODE_REF_READ: begin
        if (!op_ok) begin
          res_status = ST_BADADDR;
        end else begin
          res_refs = ref_rd;
          priority case (op_mode)
            MODE_FREE: begin
              if (ref_rd != REF_BITS'(1)) begin
                res_status = ST_SHARED;
              end else begin
                do_push = 1'b1;
              end
            end
            MODE_FREE_UNCHK: begin
              do_push = 1'b1;
            end
            MODE_REF_INC: begin
              if (ref_rd == REF_MAX) begin
                res_status = ST_COUNT;
              end else begin
                ref_we    = cmd.exec;
                ref_wdata = ref_rd + 1'b1;
                res_refs  = ref_rd + 1'b1;
              end
            end
            MODE_REF_DEC: begin
              if (ref_rd == '0) begin
                res_status = ST_COUNT;
              end else begin
                ref_we    = cmd.exec;
                ref_wdata = ref_rd - 1'b1;
                res_refs  = ref_rd - 1'b1;
              end
            end
            default: ;  // read count: nothing to change
          endcase
        end
      end
      default: ;  // count free and no-op leave the state alone
    endcase

    // push the frame as the new head
    if (do_push) begin
      link_we         = cmd.exec;
      ref_we          = cmd.exec;
      ref_wdata       = '0;
      res_refs        = '0;
      head_index_next = op_idx;
      head_valid_next = 1'b1;
      if (free_total != FREE_MAX) begin
        free_total_next = free_total + 1'b1;
      end
    end

    // clearing pass owns the count store write port
    if (cmd.clear) begin
      ref_we    = 1'b1;
      ref_waddr = clr_cnt;
      ref_wdata = '0;
    end

    refs_wide = 16'(res_refs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      head_valid <= 1'b0;
      free_total <= '0;
    end else if (cmd.exec) begin
      head_index <= head_index_next;
      head_valid <= head_valid_next;
      free_total <= free_total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status      <= res_status;
      page_addr   <= res_page;
      ref_count   <= refs_wide[REFOUT_W-1:0];
      free_frames <= free_total_next;
    end
  end

endmodule

FILE: rtl/core/refcounted_page_free_list.sv
// Top level of the reference-counted page frame allocator.
//
//   channel  direction  words carried
//   req      in         mode, phys_addr
//   rsp      out        status, page_addr, ref_count, free_frames
//   cfg_*    in         register writes: 0 low_limit, 1 high_limit
//
// For each word, the accept cycle issues the registered reads of the link and
// count memories; the update, which waits while the output register is held,
// applies the operation and writes them back. The next word can be accepted
// in the cycle after the update. After reset a clearing pass zeroes the count
// store with req.ready low; configuration writes are taken throughout.
// A result waits in the output register; one further word may be accepted
// meanwhile, and its update waits until the register is free.
module refcounted_page_free_list import rpfl_pkg::*; #(
  parameter int NUM_FRAMES = 65536,
  parameter int PAGE_SHIFT = 12,
  parameter int REF_BITS   = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  rpfl_req_if.sink             req,
  rpfl_rsp_if.source           rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  rpfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpfl_dpath #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .REF_BITS   (REF_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mode        (req.mode),
    .phys_addr   (req.phys_addr),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .status      (rsp.status),
    .page_addr   (rsp.page_addr),
    .ref_count   (rsp.ref_count),
    .free_frames (rsp.free_frames),
    .cmd         (cmd),
    .stat        (stat)
  );

`ifndef ASSERT_OFF
  // a new result only appears after an update cycle
  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.exec))
    else $error("response raised without an update");

  // an update never overwrites an unclaimed result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!rsp.valid || rsp.ready))
    else $error("update while output register held");

  // words are taken one at a time
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !cmd.load)
    else $error("second word accepted before update");

  // no word is accepted during the clearing pass
  a_no_load_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !req.ready)
    else $error("request ready during clearing pass");
`endif

endmodule
